FILE: hw/rtl/nonce_replay_filter_unit_defines.svh
// assertion macros for the nonce replay filter
// used by nonce_replay_filter_unit; expects clk and rst in the including scope
`ifndef NONCE_REPLAY_FILTER_UNIT_DEFINES_SVH
`define NONCE_REPLAY_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NRF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nrf assertion failed");
// next-cycle implication
`define NRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nrf assertion failed");
`else
`define NRF_ASSERT_IMPL(label, ante, cons)
`define NRF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hw/rtl/nrf_pkg.sv
// constants, types and the nonce trim function of the nonce replay filter
// no dependencies
package nrf_pkg;

  localparam int RING_DEPTH = 32;
  localparam int NONCE_W    = 64;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int NBYTES     = 2 * NONCE_W / 8;

  typedef struct packed {
    logic [NONCE_W-1:0] high;
    logic [NONCE_W-1:0] low;
  } nonce_t;

  // clear every byte after the first zero byte, first byte at the top
  function automatic nonce_t trim_nonce(input nonce_t raw);
    logic [2*NONCE_W-1:0] bits;
    logic [2*NONCE_W-1:0] res;
    logic                 ended;
    nonce_t               result;
    bits  = raw;
    res   = '0;
    ended = 1'b0;
    for (int k = 0; k < NBYTES; k++) begin
      if (!ended) begin
        res[2*NONCE_W-1-8*k -: 8] = bits[2*NONCE_W-1-8*k -: 8];
      end
      ended = ended | (bits[2*NONCE_W-1-8*k -: 8] == 8'h00);
    end
    result = res;
    return result;
  endfunction

endpackage

FILE: hw/rtl/nrf_in_if.sv
// valid/ready channel carrying one nonce per transaction
// depends on nrf_pkg
interface nrf_in_if;
  import nrf_pkg::*;

  logic               valid;
  logic               ready;
  logic [NONCE_W-1:0] nonce_high;
  logic [NONCE_W-1:0] nonce_low;

  modport source (output valid, output nonce_high, output nonce_low, input ready);
  modport sink (input valid, input nonce_high, input nonce_low, output ready);
endinterface

FILE: hw/rtl/nrf_out_if.sv
// valid/ready channel carrying one replay verdict per transaction
// no dependencies
interface nrf_out_if;
  logic valid;
  logic ready;
  logic replay_seen;

  modport source (output valid, output replay_seen, input ready);
  modport sink (input valid, input replay_seen, output ready);
endinterface

FILE: hw/rtl/nonce_replay_filter_unit.sv
// nonce replay filter: ring of recent nonces, sequential scan, insert on miss
// depends on nrf_pkg, nrf_in_if, nrf_out_if and nonce_replay_filter_unit_defines.svh
//
//   channel  dir  payload                    meaning
//   req      in   nonce_high, nonce_low      one nonce, zero padded
//   rsp      out  replay_seen                1 = already held, 0 = recorded
//
// a nonce is scanned against the fill_count newest entries by the single-port
// ring read walked one entry per cycle and the shared 128-bit compare behind it;
// a match ends the walk early
// the next nonce is taken in ST_IDLE, entered as the verdict is raised
// reset clears pointer, fill count and handshake state; ring contents are
// never cleared, only the fill_count newest entries are ever compared
// req is accepted only while idle; a finished verdict waits for rsp.ready
// while the next nonce may already be accepted
`include "nonce_replay_filter_unit_defines.svh"

module nonce_replay_filter_unit (
  input logic clk,
  input logic rst,
  nrf_in_if.sink   req,
  nrf_out_if.source rsp
);
  import nrf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // control registers
  state_t           state;
  logic [PTR_W-1:0] wp;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] issue_cnt;
  logic             cmp_vld;
  logic             seen;
  logic             out_valid;
  logic             out_seen;

  // payload registers
  nonce_t           nonce;
  nonce_t           rd_data;

  // ring memory
  nonce_t           ring [RING_DEPTH];

  logic             hit;
  logic             seen_now;
  logic             out_free;
  logic             mem_we;
  logic             issue_more;
  logic [CNT_W:0]   scan_sum;
  logic [CNT_W:0]   scan_wrap;
  logic [PTR_W-1:0] scan_addr;
  logic [PTR_W-1:0] wp_next;

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.replay_seen = out_seen;

  // shared compare of the ring entry read last cycle against the held nonce
  assign hit      = cmp_vld && (rd_data == nonce);
  assign seen_now = seen | hit;
  assign out_free = !out_valid || rsp.ready;
  assign mem_we   = (state == ST_FINISH) && out_free && !seen;
  assign issue_more = (issue_cnt < fill_count);

  // newest-first walk: address = wp - 1 - issue_cnt, modulo ring depth
  always_comb begin
    scan_sum = (CNT_W+1)'(wp) + (CNT_W+1)'(RING_DEPTH - 1) - (CNT_W+1)'(issue_cnt);
    if (scan_sum >= (CNT_W+1)'(RING_DEPTH)) begin
      scan_wrap = scan_sum - (CNT_W+1)'(RING_DEPTH);
    end else begin
      scan_wrap = scan_sum;
    end
    scan_addr = scan_wrap[PTR_W-1:0];
  end

  assign wp_next = (wp == PTR_W'(RING_DEPTH - 1)) ? '0 : wp + PTR_W'(1);

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wp] <= nonce;
    end
    rd_data <= ring[scan_addr];
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wp         <= '0;
      fill_count <= '0;
      issue_cnt  <= '0;
      cmp_vld    <= 1'b0;
      seen       <= 1'b0;
      out_valid  <= 1'b0;
      out_seen   <= 1'b0;
    end else begin
      // drop the verdict once taken, unless a new one replaces it this cycle
      if (out_valid && rsp.ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            nonce     <= trim_nonce({req.nonce_high, req.nonce_low});
            issue_cnt <= '0;
            cmp_vld   <= 1'b0;
            seen      <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          seen <= seen_now;
          if (hit) begin
            // match found, stop the walk
            cmp_vld <= 1'b0;
            state   <= ST_FINISH;
          end else if (issue_more) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
            cmp_vld   <= 1'b1;
          end else begin
            // last live entry compared, or ring empty
            cmp_vld <= 1'b0;
            state   <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_seen  <= seen;
            if (!seen) begin
              // record the new nonce, oldest entry overwritten when full
              wp <= wp_next;
              if (fill_count != CNT_W'(RING_DEPTH)) begin
                fill_count <= fill_count + CNT_W'(1);
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `NRF_ASSERT_IMPL(a_fill_bound, 1'b1, fill_count <= CNT_W'(RING_DEPTH))
  `NRF_ASSERT_NEXT(a_accept_scans, req.valid && req.ready, state == ST_SCAN)
  `NRF_ASSERT_NEXT(a_seen_keeps_ring, (state == ST_FINISH) && out_free && seen, $stable(wp) && $stable(fill_count) && rsp.valid && rsp.replay_seen)
  `NRF_ASSERT_NEXT(a_miss_records, (state == ST_FINISH) && out_free && !seen, wp != $past(wp) || RING_DEPTH == 1)

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for nonce_replay_filter_unit: directed rows then random nonce traffic
// depends on nrf_pkg, nrf_in_if, nrf_out_if and the unit itself
module tb_top;
  import nrf_pkg::*;

  // verdict a directed row carries: typed in, or left to the replay predictor
  typedef enum logic [1:0] {
    VERDICT_NEW,
    VERDICT_SEEN,
    VERDICT_PREDICTED
  } verdict_t;

  typedef struct {
    nonce_t   raw;
    verdict_t code;
  } probe_row_t;

  localparam int RANDOM_NONCES = 1150;
  localparam int HISTORY_MAX   = 64;      // beyond the ring depth, so evicted nonces come back
  localparam int IDLE_PCT      = 14;
  localparam int STEADY_FROM   = 500;     // transaction count where idling pauses
  localparam int STEADY_TO     = 700;
  localparam int HOLD_AT       = 250;     // verdict count where the long hold-off starts
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 2 * RING_DEPTH + 8;
  localparam int CYCLE_LIMIT   = 400000;

  logic clk;
  logic rst;

  nrf_in_if  req_ch ();
  nrf_out_if rsp_ch ();

  nonce_replay_filter_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // replay predictor state: recorded nonces, next slot and number of live entries
  logic [NONCE_W-1:0] seen_high [RING_DEPTH];
  logic [NONCE_W-1:0] seen_low  [RING_DEPTH];
  int                 slot_next;
  int                 live_count;

  bit         verdict_q [$];    // expected replay_seen, oldest first
  nonce_t     history_q [$];    // raw nonces sent lately, source of replays
  probe_row_t probe_rows [$];

  int accepted_cnt;
  int verdict_cnt;
  int mismatch_cnt;
  int cycle_cnt;
  bit hold_done;

  // clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // byte index of the first zero byte, byte 0 at the top; 16 when there is none
  function automatic int first_zero_byte(input nonce_t raw);
    logic [2*NONCE_W-1:0] v;
    v = raw;
    for (int k = 0; k < NBYTES; k++) begin
      if (v[2*NONCE_W-1-8*k -: 8] == 8'h00) return k;
    end
    return NBYTES;
  endfunction

  // the nonce ends at its first zero byte, everything below it reads as zero
  function automatic nonce_t cut_at_terminator(input nonce_t raw);
    logic [2*NONCE_W-1:0] v;
    logic [2*NONCE_W-1:0] tail;
    int                   p;
    v = raw;
    p = first_zero_byte(raw);
    if (p < NBYTES - 1) begin
      tail = {(2*NONCE_W){1'b1}} >> (8 * (p + 1));
      v    = v & ~tail;
    end
    return nonce_t'(v);
  endfunction

  // scan the live entries; on a miss record the nonce, oldest entry goes when full
  function automatic bit record_nonce(input nonce_t raw);
    nonce_t key;
    bit     hit;
    int     idx;
    key = cut_at_terminator(raw);
    hit = 1'b0;
    for (int i = 0; i < live_count; i++) begin
      idx = (slot_next + RING_DEPTH - 1 - i) % RING_DEPTH;
      if (seen_high[idx] == key.high && seen_low[idx] == key.low) hit = 1'b1;
    end
    if (!hit) begin
      seen_high[slot_next] = key.high;
      seen_low[slot_next]  = key.low;
      slot_next            = (slot_next + 1) % RING_DEPTH;
      if (live_count < RING_DEPTH) live_count++;
    end
    return hit;
  endfunction

  function automatic bit idle_roll();
    if (accepted_cnt >= STEADY_FROM && accepted_cnt < STEADY_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  task automatic add_row(input logic [NONCE_W-1:0] high, input logic [NONCE_W-1:0] low,
                         input verdict_t code);
    probe_row_t row;
    row.raw.high = high;
    row.raw.low  = low;
    row.code     = code;
    probe_rows.push_back(row);
  endtask

  // offer one nonce from a falling edge, return at the falling edge after the transaction
  task automatic send_nonce(input nonce_t raw, input verdict_t code);
    bit predicted;
    while (idle_roll()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.nonce_high <= raw.high;
    req_ch.nonce_low  <= raw.low;
    do @(posedge clk); while (!req_ch.ready);
    // predictor runs in acceptance order, typed rows override its verdict
    predicted = record_nonce(raw);
    if (code == VERDICT_PREDICTED) verdict_q.push_back(predicted);
    else verdict_q.push_back(code == VERDICT_SEEN);
    history_q.push_back(raw);
    if (history_q.size() > HISTORY_MAX) void'(history_q.pop_front());
    accepted_cnt++;
    @(negedge clk);
  endtask

  // random nonce: half the time a replay of recent traffic, some with junk after the end
  function automatic nonce_t pick_nonce();
    nonce_t               raw;
    logic [2*NONCE_W-1:0] v;
    int                   roll;
    int                   p;
    roll = $urandom_range(0, 99);
    if (roll < 35 && history_q.size() > 0) begin
      raw = history_q[$urandom_range(0, history_q.size() - 1)];
    end else if (roll < 50 && history_q.size() > 0) begin
      // same nonce up to its terminator, different bytes after it
      v = history_q[$urandom_range(0, history_q.size() - 1)];
      p = first_zero_byte(nonce_t'(v));
      for (int k = p + 1; k < NBYTES; k++) v[2*NONCE_W-1-8*k -: 8] = 8'($urandom_range(0, 255));
      raw = nonce_t'(v);
    end else begin
      v = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 99) < 30) begin
        p = $urandom_range(0, NBYTES - 1);
        v[2*NONCE_W-1-8*p -: 8] = 8'h00;
      end
      if ($urandom_range(0, 199) == 0) v = '0;
      raw = nonce_t'(v);
    end
    return raw;
  endfunction

  // stimulus: reset, directed rows, random traffic, drain
  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.nonce_high = '0;
    req_ch.nonce_low  = '0;
    slot_next         = 0;
    live_count        = 0;
    accepted_cnt      = 0;

    // empty nonce, then a nonce whose first byte is zero (also empty)
    add_row(64'h0, 64'h0, VERDICT_NEW);
    add_row(64'h0, 64'h0, VERDICT_SEEN);
    add_row(64'h00FF_FFFF_FFFF_FFFF, 64'hDEAD_BEEF_CAFE_F00D, VERDICT_SEEN);
    // all bits set, full 16-byte nonce
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, VERDICT_NEW);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, VERDICT_SEEN);
    // terminator in the high half, bytes after it differ
    add_row(64'h4142_4344_0055_6677, 64'h1234_5678_9ABC_DEF0, VERDICT_NEW);
    add_row(64'h4142_4344_0099_8877, 64'hFFFF_FFFF_FFFF_FFFF, VERDICT_SEEN);
    // sixteen bytes with the last one zero, then one differing only in the last byte
    add_row(64'h0102_0304_0506_0708, 64'h1112_1314_1516_1700, VERDICT_NEW);
    add_row(64'h0102_0304_0506_0708, 64'h1112_1314_1516_1718, VERDICT_NEW);
    add_row(64'h0102_0304_0506_0708, 64'h1112_1314_1516_1700, VERDICT_PREDICTED);
    // terminator in the low half
    add_row(64'h0102_0304_0506_0708, 64'h1112_0044_5566_7788, VERDICT_NEW);
    add_row(64'h0102_0304_0506_0708, 64'h1112_00FF_FFFF_FFFF, VERDICT_SEEN);
    // high all ones, low ending at once
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, VERDICT_NEW);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 64'h00AB_CDEF_0123_4567, VERDICT_SEEN);
    // one-byte nonce with the top bit set
    add_row(64'h8000_0000_0000_0001, 64'h0, VERDICT_PREDICTED);
    add_row(64'h8000_1234_5678_9ABC, 64'h5555_AAAA_5555_AAAA, VERDICT_PREDICTED);
    add_row(64'h7FFF_FFFF_FFFF_FFFE, 64'hAAAA_5555_AAAA_5501, VERDICT_PREDICTED);
    add_row(64'h7FFF_FFFF_FFFF_FFFE, 64'hAAAA_5555_AAAA_5501, VERDICT_SEEN);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (probe_rows[i]) send_nonce(probe_rows[i].raw, probe_rows[i].code);
    for (int n = 0; n < RANDOM_NONCES; n++) send_nonce(pick_nonce(), VERDICT_PREDICTED);
    req_ch.valid <= 1'b0;

    // every verdict in, then a quiet stretch to catch anything extra
    wait (verdict_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // verdict side ready: random stalls, plus one long hold-off so the unit backs up
  initial begin
    int hold_left;
    rsp_ch.ready = 1'b0;
    hold_done    = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && verdict_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !idle_roll();
      end
    end
  end

  // check each verdict transaction against the oldest pending expectation
  always @(posedge clk) begin
    bit want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      verdict_cnt++;
      if (verdict_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected verdict %0b with nothing pending at cycle %0d",
                   rsp_ch.replay_seen, cycle_cnt);
      end else begin
        want = verdict_q.pop_front();
        if (rsp_ch.replay_seen !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("verdict %0d: replay_seen expected %0b got %0b at cycle %0d",
                     verdict_cnt, want, rsp_ch.replay_seen, cycle_cnt);
        end
      end
    end
  end

endmodule
